### rtl/fps_pkg.sv
// ----------------------------------------------------------------------------
// fps_pkg
// Shared constants, codes and types of the Fenwick prefix-sum table.
// ----------------------------------------------------------------------------
package fps_pkg;

  localparam int NUM_POSITIONS = 1024;
  localparam int ADDR_W        = $clog2(NUM_POSITIONS);
  // node index of the walks, wide enough to hold twice the table size
  localparam int KW            = ADDR_W + 2;

  localparam int DATA_W    = 32;
  localparam int POS_W     = 10;
  localparam int CFG_W     = 10;
  localparam int OP_W      = 3;
  localparam int ST_W      = 2;
  localparam int IN_RAW_W  = 2 * POS_W + DATA_W;
  localparam int IN_DATA_W = ((IN_RAW_W + 7) / 8) * 8;

  localparam logic [CFG_W-1:0] LAST_POS_RESET = CFG_W'(1023);

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 3'd0,
    OP_SET    = 3'd1,
    OP_PREFIX = 3'd2,
    OP_RANGE  = 3'd3,
    OP_READ   = 3'd4
  } opcode_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_ORDER = 2'd2
  } status_e;

  // port controls of the two stores
  typedef struct packed {
    logic [ADDR_W-1:0] t_raddr;
    logic              t_we;
    logic [ADDR_W-1:0] t_waddr;
    logic [DATA_W-1:0] t_wdata;
    logic [ADDR_W-1:0] v_raddr;
    logic              v_we;
    logic [ADDR_W-1:0] v_waddr;
    logic [DATA_W-1:0] v_wdata;
  } mem_ctrl_t;

endpackage

### rtl/fps_store.sv
// ----------------------------------------------------------------------------
// fps_store
// Tree node store and value store, one write and one registered read each.
// ----------------------------------------------------------------------------
module fps_store import fps_pkg::*; (
  input  logic              clk_i,
  input  mem_ctrl_t         ctrl_i,
  output logic [DATA_W-1:0] t_rdata_o,
  output logic [DATA_W-1:0] v_rdata_o
);

  logic [DATA_W-1:0] tree_mem  [NUM_POSITIONS];
  logic [DATA_W-1:0] value_mem [NUM_POSITIONS];
  logic [DATA_W-1:0] t_rdata_q;
  logic [DATA_W-1:0] v_rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.t_we) begin
      tree_mem[ctrl_i.t_waddr] <= ctrl_i.t_wdata;
    end
    t_rdata_q <= tree_mem[ctrl_i.t_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.v_we) begin
      value_mem[ctrl_i.v_waddr] <= ctrl_i.v_wdata;
    end
    v_rdata_q <= value_mem[ctrl_i.v_raddr];
  end

  assign t_rdata_o = t_rdata_q;
  assign v_rdata_o = v_rdata_q;

endmodule

### rtl/fenwick_prefix_sum_table.sv
// ----------------------------------------------------------------------------
// fenwick_prefix_sum_table
// Binary indexed tree with add, set, prefix sum, range sum and read value.
//
//   channel   direction  signals                 content
//   s_axis    in         tvalid tready tdata     position, end_position, value
//                        tuser                   opcode
//   m_axis    out        tvalid tready tdata     result_value
//                        tuser                   status
//   cfg       in         we wdata                last_position
//
// After reset both stores are cleared one entry a cycle, with tready low
// until all 1024 entries are cleared. One item at a time, walks go one tree
// node per cycle through a single 32-bit adder: prefix sum visits up to 10
// nodes, add and set up to 11, range sum two walks of up to 19 nodes together.
// A result waits in the output register while m_axis_tready_i is low.
// ----------------------------------------------------------------------------
module fenwick_prefix_sum_table import fps_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // [9:0] position, [19:10] end_position, [51:20] value, [55:52] zero
  input  logic [IN_DATA_W-1:0] s_axis_tdata_i,
  // [2:0] opcode
  input  logic [OP_W-1:0]      s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // [31:0] result_value
  output logic [DATA_W-1:0]    m_axis_tdata_o,
  // [1:0] status
  output logic [ST_W-1:0]      m_axis_tuser_o
);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_VREAD = 7'b0000100,
    S_VCALC = 7'b0001000,
    S_WALK  = 7'b0010000,
    S_DRAIN = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] clr_q;
  logic [CFG_W-1:0]  last_q;
  logic [OP_W-1:0]   op_q;
  logic [POS_W-1:0]  pos_q;
  logic [DATA_W-1:0] val_q;
  logic [DATA_W-1:0] delta_q;
  logic [DATA_W-1:0] acc_q;
  logic [KW-1:0]     k_q;
  logic [ADDR_W-1:0] addr_q;
  logic              pend_q;
  logic              up_q;
  logic              sub_q;
  logic              second_q;
  status_e           status_q;
  logic              m_valid_q;
  logic [DATA_W-1:0] m_data_q;
  logic [ST_W-1:0]   m_user_q;

  logic [POS_W-1:0]  in_pos, in_endp, lim;
  logic [DATA_W-1:0] in_val;
  logic [OP_W-1:0]   in_op;
  logic              in_known;
  status_e           chk;
  logic              accept, out_free;

  logic [KW-1:0]     lowbit, k_up, k_dn, k_nxt;
  logic              walk_done;
  logic [DATA_W-1:0] add_a, add_b, add_y;
  logic              add_sub;
  logic [DATA_W-1:0] t_rdata, v_rdata;
  mem_ctrl_t         mc;

  assign in_op   = s_axis_tuser_i;
  assign in_pos  = s_axis_tdata_i[POS_W-1:0];
  assign in_endp = s_axis_tdata_i[2*POS_W-1:POS_W];
  assign in_val  = s_axis_tdata_i[2*POS_W+DATA_W-1:2*POS_W];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;

  always_comb begin
    if (int'(last_q) > NUM_POSITIONS - 1) begin
      lim = POS_W'(NUM_POSITIONS - 1);
    end else begin
      lim = last_q;
    end
  end

  assign in_known = (in_op == OP_ADD) || (in_op == OP_SET) || (in_op == OP_PREFIX) ||
                    (in_op == OP_RANGE) || (in_op == OP_READ);

  always_comb begin
    chk = ST_OK;
    case (in_op)
      OP_ADD, OP_SET, OP_PREFIX, OP_READ: begin
        if (in_pos > lim) chk = ST_RANGE;
      end
      OP_RANGE: begin
        if (in_pos > lim || in_endp > lim) chk = ST_RANGE;
        else if (in_pos > in_endp) chk = ST_ORDER;
      end
      default: chk = ST_OK;
    endcase
  end

  // next node: upward for updates, downward for sums
  assign lowbit    = k_q & (~k_q + KW'(1));
  assign k_up      = k_q + lowbit;
  assign k_dn      = k_q - lowbit;
  assign k_nxt     = up_q ? k_up : k_dn;
  assign walk_done = up_q ? (k_up > KW'(NUM_POSITIONS)) : (k_dn == '0);

  // the one shared adder
  always_comb begin
    if (state_q == S_VCALC) begin
      if (op_q == OP_SET) begin
        add_a   = val_q;
        add_b   = v_rdata;
        add_sub = 1'b1;
      end else begin
        add_a   = v_rdata;
        add_b   = val_q;
        add_sub = 1'b0;
      end
    end else if (up_q) begin
      add_a   = t_rdata;
      add_b   = delta_q;
      add_sub = 1'b0;
    end else begin
      add_a   = acc_q;
      add_b   = t_rdata;
      add_sub = sub_q;
    end
  end

  assign add_y = add_a + (add_sub ? ~add_b : add_b) + DATA_W'(add_sub);

  always_comb begin
    mc.t_raddr = ADDR_W'(k_q - KW'(1));
    mc.v_raddr = ADDR_W'(pos_q);
    if (state_q == S_CLEAR) begin
      mc.t_we    = 1'b1;
      mc.t_waddr = clr_q;
      mc.t_wdata = '0;
      mc.v_we    = 1'b1;
      mc.v_waddr = clr_q;
      mc.v_wdata = '0;
    end else begin
      mc.t_we    = pend_q && up_q;
      mc.t_waddr = addr_q;
      mc.t_wdata = add_y;
      mc.v_we    = (state_q == S_VCALC) && ((op_q == OP_ADD) || (op_q == OP_SET));
      mc.v_waddr = ADDR_W'(pos_q);
      mc.v_wdata = (op_q == OP_SET) ? val_q : add_y;
    end
  end

  fps_store u_store (
    .clk_i     (clk_i),
    .ctrl_i    (mc),
    .t_rdata_o (t_rdata),
    .v_rdata_o (v_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == ADDR_W'(NUM_POSITIONS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (chk != ST_OK || !in_known) begin
            state_d = S_OUT;
          end else if (in_op == OP_PREFIX || in_op == OP_RANGE) begin
            state_d = S_WALK;
          end else begin
            state_d = S_VREAD;
          end
        end
      end
      S_VREAD: state_d = S_VCALC;
      S_VCALC: state_d = (op_q == OP_READ) ? S_OUT : S_WALK;
      S_WALK: begin
        if (walk_done) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        if (!up_q && second_q && op_q == OP_RANGE) state_d = S_WALK;
        else state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      last_q    <= LAST_POS_RESET;
      pend_q    <= 1'b0;
      up_q      <= 1'b0;
      sub_q     <= 1'b0;
      second_q  <= 1'b0;
      status_q  <= ST_OK;
      op_q      <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= (state_q == S_WALK);
      if (cfg_we_i) begin
        last_q <= cfg_wdata_i;
      end
      if (state_q == S_OUT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: clr_q <= clr_q + ADDR_W'(1);
        S_IDLE: begin
          if (accept) begin
            op_q     <= in_op;
            status_q <= chk;
            up_q     <= 1'b0;
            sub_q    <= 1'b0;
            second_q <= (in_pos != '0);
          end
        end
        S_VCALC: up_q <= (op_q != OP_READ);
        S_DRAIN: begin
          if (!up_q && second_q) begin
            second_q <= 1'b0;
            sub_q    <= 1'b1;
          end
        end
        S_OUT: begin
          if (out_free) begin
            up_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (pend_q && !up_q) begin
      acc_q <= add_y;
    end
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          pos_q <= in_pos;
          val_q <= in_val;
          acc_q <= '0;
          k_q   <= KW'((in_op == OP_RANGE) ? in_endp : in_pos) + KW'(1);
        end
      end
      S_VCALC: begin
        delta_q <= (op_q == OP_SET) ? add_y : val_q;
        k_q     <= KW'(pos_q) + KW'(1);
        if (op_q == OP_READ) acc_q <= v_rdata;
      end
      S_WALK: begin
        k_q    <= k_nxt;
        addr_q <= mc.t_raddr;
      end
      // second walk covers the prefix up to position minus one
      S_DRAIN: k_q <= KW'(pos_q);
      S_OUT: begin
        if (out_free) begin
          m_data_q <= acc_q;
          m_user_q <= status_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule

### rtl/fps_checker.sv
// ----------------------------------------------------------------------------
// fps_checker
// Port-level checks of the Fenwick prefix-sum table, bound to the top level.
// ----------------------------------------------------------------------------
module fps_checker import fps_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 cfg_we_i,
  input logic [CFG_W-1:0]     cfg_wdata_i,
  input logic                 s_axis_tvalid_i,
  input logic                 s_axis_tready_o,
  input logic [IN_DATA_W-1:0] s_axis_tdata_i,
  input logic [OP_W-1:0]      s_axis_tuser_i,
  input logic                 m_axis_tvalid_o,
  input logic                 m_axis_tready_i,
  input logic [DATA_W-1:0]    m_axis_tdata_o,
  input logic [ST_W-1:0]      m_axis_tuser_o
);

  // one item in flight: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("ready high right after an accepted item");

  // an error result carries a zero value
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != ST_OK) |-> m_axis_tdata_o == '0)
    else $error("error result with nonzero value");

  // no result without an item since the last one: idle block stays empty
  a_result_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && s_axis_tready_o |=> !m_axis_tvalid_o)
    else $error("unexpected back-to-back result");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result dropped or changed");

endmodule

bind fenwick_prefix_sum_table fps_checker u_fps_checker (.*);
